// ----- sv/kpsb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsb_pkg: shared types and constants for the keypad scan key buffer
// Item structs, classified operation codes and the key decode function.
// ----------------------------------------------------------------------------
package kpsb_pkg;

    // Key ring
    localparam int RING_DEPTH = 4;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    // Queue between classifier and executor
    localparam int QDEPTH = 2;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Input commands
    localparam logic [1:0] CMD_ROW     = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // Classified operations
    localparam logic [1:0] OP_NOP     = 2'd0;
    localparam logic [1:0] OP_KEY     = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    // Key codes for the bottom row
    localparam logic [4:0] CODE_STAR = 5'd20;
    localparam logic [4:0] CODE_ZERO = 5'd0;
    localparam logic [4:0] CODE_HASH = 5'd30;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] row_index;
        logic [2:0] column_lines;
    } t_in_item;

    typedef struct packed {
        logic       key_stored;
        logic       read_valid;
        logic [4:0] read_key;
    } t_out_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] code;
    } t_op;

    // Row 0..2 give digits row*3+col+1; row 3 gives star, zero, hash.
    function automatic logic [4:0] key_code(input logic [1:0] row, input logic [1:0] col);
        logic [4:0] digit;
        digit = 5'({row, 1'b0}) + 5'(row) + 5'(col) + 5'd1;
        if (row != 2'd3) begin
            return digit;
        end
        case (col)
            2'd0:    return CODE_STAR;
            2'd1:    return CODE_ZERO;
            default: return CODE_HASH;
        endcase
    endfunction

endpackage

// ----- sv/kpsb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsb_front: command classifier
// Accepts input items, decodes the column lines and registers one operation.
// ----------------------------------------------------------------------------
module kpsb_front
    import kpsb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    output logic     o_op_valid,
    output t_op      o_op,
    input  logic     i_q_full
);

    logic       r_fv;
    t_op        r_fop;
    t_op        n_fop;
    logic [1:0] col;
    logic       any_col;
    logic       push;
    logic       take;

    // lowest-numbered active (low) column wins
    always_comb begin
        any_col = 1'b1;
        col     = 2'd0;
        if (!i_in_data.column_lines[0]) begin
            col = 2'd0;
        end else if (!i_in_data.column_lines[1]) begin
            col = 2'd1;
        end else if (!i_in_data.column_lines[2]) begin
            col = 2'd2;
        end else begin
            any_col = 1'b0;
        end
    end

    always_comb begin
        n_fop.code = key_code(i_in_data.row_index, col);
        case (i_in_data.command)
            CMD_ROW:     n_fop.kind = any_col ? OP_KEY : OP_NOP;
            CMD_READ:    n_fop.kind = OP_READ;
            CMD_RELEASE: n_fop.kind = OP_RELEASE;
            default:     n_fop.kind = OP_NOP;
        endcase
    end

    assign push       = r_fv && !i_q_full;
    assign o_in_stall = r_fv && i_q_full;
    assign take       = i_in_valid && !o_in_stall;
    assign o_op_valid = push;
    assign o_op       = r_fop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (take) begin
            r_fv <= 1'b1;
        end else if (push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_fop <= n_fop;
        end
    end

endmodule

// ----- sv/kpsb_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsb_queue: operation queue
// Short FIFO that decouples the classifier from the executor.
// ----------------------------------------------------------------------------
module kpsb_queue
    import kpsb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_nonempty,
    output t_op  o_head,
    input  logic i_pop
);

    t_op               r_mem [QDEPTH];
    logic [QIDX_W-1:0] r_wr;
    logic [QIDX_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full     = (r_cnt == QCNT_W'(QDEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

// ----- sv/kpsb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpsb_back: key ring executor
// Applies queued operations to the key ring and registers one result item.
// ----------------------------------------------------------------------------
module kpsb_back
    import kpsb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_nonempty,
    input  t_op       i_op,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic [4:0]       r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_full;
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [4:0]       r_last;
    logic             r_known;
    logic             r_out_valid;
    t_out_item        r_out;

    t_out_item        n_out;
    logic             exec;
    logic             do_store;
    logic             do_read;

    // output register is free or being drained this cycle
    assign exec  = i_q_nonempty && (!r_out_valid || !i_out_stall);
    assign o_pop = exec;

    assign do_store = exec && (i_op.kind == OP_KEY) && (!r_known || i_op.code != r_last);
    assign do_read  = exec && (i_op.kind == OP_READ) && r_full[r_rp];

    always_comb begin
        n_out            = '0;
        n_out.key_stored = do_store;
        n_out.read_valid = do_read;
        if (do_read) begin
            n_out.read_key = r_ring[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full      <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_last      <= '0;
            r_known     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (do_store) begin
                r_full[r_wp] <= 1'b1;
                r_wp    <= (r_wp == PTR_W'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                r_last  <= i_op.code;
                r_known <= 1'b1;
            end
            if (do_read) begin
                r_full[r_rp] <= 1'b0;
                r_rp <= (r_rp == PTR_W'(RING_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (exec && i_op.kind == OP_RELEASE) begin
                r_known <= 1'b0;
            end
        end
    end

    // entry payload; an empty entry is never returned, so no clear is needed
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_ring[r_wp] <= i_op.code;
        end
        if (exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a stored key always becomes the known last key
    a_store_sets_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_store |=> (r_known && r_last == $past(i_op.code)))
        else $error("stored key not recorded as last key");

    // a successful read empties the entry it came from
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_read |=> !r_full[$past(r_rp)])
        else $error("read entry still marked full");

    // one result never reports both a store and a read
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.key_stored && r_out.read_valid))
        else $error("result reports store and read together");

    // an empty-read or non-read result carries a zero key
    a_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.read_valid) |-> (r_out.read_key == 5'd0))
        else $error("nonzero key on result without a read");

endmodule

// ----- sv/keypad_scan_key_buffer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_scan_key_buffer_top: 4x3 keypad scanner with a key ring buffer
// Decodes row samples to key codes, buffers new keys, serves reads.
// ----------------------------------------------------------------------------
// Path: an item passes the classifier register, the queue and the result
//   register before its result is valid, and longer while the output is
//   stalled.
// Throughput: one item per clock unless the output stalls; the executor's
//   single result register and the two-entry operation queue set that figure.
// Reset: synchronous, active low; clears ring marks, pointers, last key and
//   all valid flags. Ready for items in the first cycle after reset.
// ----------------------------------------------------------------------------
module keypad_scan_key_buffer_top
    import kpsb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input item channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    // result item channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // classifier -> queue
    logic q_push;
    t_op  q_in_op;
    logic q_full;
    // queue -> executor
    logic q_nonempty;
    t_op  q_head;
    logic q_pop;

    // Front: decode command and column lines into one operation per item.
    kpsb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_op_valid (q_push),
        .o_op       (q_in_op),
        .i_q_full   (q_full)
    );

    // Queue: lets the front keep taking items while the back waits on output.
    kpsb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_op       (q_in_op),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head),
        .i_pop      (q_pop)
    );

    // Back: owns the ring state, executes one operation per cycle while its
    // output register is free or draining, and holds the result there until taken.
    kpsb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_op         (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the keypad scan key buffer
// A short table of directed key events is followed by random scan traffic.
// Every accepted item runs through a local keypad model, and each result
// item is checked field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;
    import kpsb_pkg::*;

    // Command 3 has no meaning; the block must answer all zeros and keep state.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Receiver stall patterns
    localparam logic [1:0] STALL_NONE   = 2'd0;
    localparam logic [1:0] STALL_SPARSE = 2'd1;
    localparam logic [1:0] STALL_DENSE  = 2'd2;
    localparam logic [1:0] STALL_TOGGLE = 2'd3;

    // Traffic mixes for the random part
    localparam int unsigned MIX_WRITES   = 0;
    localparam int unsigned MIX_READS    = 1;
    localparam int unsigned MIX_BALANCED = 2;

    localparam int RANDOM_ITEMS    = 1900;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_AT     = 700;   // items accepted before the long stall
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 12;
    localparam int REPORT_LIMIT    = 10;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    keypad_scan_key_buffer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Keypad model: ring of key codes with occupied marks, two pointers and
    // the last stored key, which suppresses repeats until a release tick.
    // ------------------------------------------------------------------------
    logic [4:0]  ring_codes [RING_DEPTH];
    logic        ring_used  [RING_DEPTH];
    int unsigned wr_slot;
    int unsigned rd_slot;
    logic [4:0]  last_code;
    logic        last_code_known;

    t_out_item   pending_results [$];
    int          mismatches     = 0;
    int          items_accepted = 0;

    // Rows 0..2 are the digit rows; row 3 holds star, zero and hash.
    function automatic logic [4:0] decode_key(logic [1:0] row, int col);
        if (row != 2'd3) begin
            return 5'(int'(row) * 3 + col + 1);
        end
        case (col)
            0:       return CODE_STAR;
            1:       return CODE_ZERO;
            default: return CODE_HASH;
        endcase
    endfunction

    function automatic t_out_item predict_key_event(t_in_item it);
        t_out_item  res;
        int         col;
        logic [4:0] code;
        res = '0;
        col = -1;
        case (it.command)
            CMD_ROW: begin
                // active low; lowest column wins when several are pressed
                if (!it.column_lines[0]) begin
                    col = 0;
                end else if (!it.column_lines[1]) begin
                    col = 1;
                end else if (!it.column_lines[2]) begin
                    col = 2;
                end
                if (col >= 0) begin
                    code = decode_key(it.row_index, col);
                    if (!last_code_known || code != last_code) begin
                        // a full ring is simply overwritten at the write slot
                        ring_codes[wr_slot] = code;
                        ring_used[wr_slot]  = 1'b1;
                        wr_slot             = (wr_slot + 1) % RING_DEPTH;
                        last_code           = code;
                        last_code_known     = 1'b1;
                        res.key_stored      = 1'b1;
                    end
                end
            end
            CMD_READ: begin
                // an empty slot at the read pointer leaves the pointer alone
                if (ring_used[rd_slot]) begin
                    res.read_valid      = 1'b1;
                    res.read_key        = ring_codes[rd_slot];
                    ring_codes[rd_slot] = '0;
                    ring_used[rd_slot]  = 1'b0;
                    rd_slot             = (rd_slot + 1) % RING_DEPTH;
                end
            end
            CMD_RELEASE: begin
                last_code_known = 1'b0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%s", what);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table. Rows with typed = 1 carry an answer readable by eye;
    // the rest take the model's answer.
    // ------------------------------------------------------------------------
    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_scan_step;

    t_scan_step directed_steps [$];

    task automatic add_step(logic [1:0] cmd, logic [1:0] row, logic [2:0] lines,
                            bit typed, logic stored, logic rvalid, logic [4:0] rkey);
        t_scan_step s;
        s.stim  = '{command: cmd, row_index: row, column_lines: lines};
        s.typed = typed;
        s.want  = '{key_stored: stored, read_valid: rvalid, read_key: rkey};
        directed_steps.push_back(s);
    endtask

    // ------------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them. Valid stays
    // high across a burst, so each falling edge sees at most one update.
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;

    task automatic send_item(t_in_item it, bit typed, t_out_item want);
        t_out_item   predicted;
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predicted = predict_key_event(it);
        pending_results.push_back(typed ? want : predicted);
        items_accepted++;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            // now and then a long unbroken burst
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Random scan traffic: mostly clean single-key presses, with held keys
    // repeating the previous sample, releases, reads and a little noise.
    logic [1:0] held_row   = 2'd0;
    logic [2:0] held_lines = 3'b111;

    function automatic t_in_item make_scan_item(int unsigned mix);
        t_in_item    it;
        int unsigned pick;
        int unsigned row_w;
        int unsigned read_w;
        int unsigned rel_w;
        case (mix)
            MIX_WRITES: begin
                row_w = 60; read_w = 15; rel_w = 20;
            end
            MIX_READS: begin
                row_w = 20; read_w = 65; rel_w = 10;
            end
            default: begin
                row_w = 40; read_w = 35; rel_w = 20;
            end
        endcase
        pick            = $urandom_range(0, 99);
        it.row_index    = 2'($urandom_range(0, 3));
        it.column_lines = 3'($urandom_range(0, 7));
        if (pick < row_w) begin
            it.command = CMD_ROW;
            if ($urandom_range(0, 3) == 0) begin
                // key still held down: same sample again
                it.row_index    = held_row;
                it.column_lines = held_lines;
            end else if ($urandom_range(0, 7) != 0) begin
                it.column_lines = ~(3'b001 << $urandom_range(0, 2));
            end
            held_row   = it.row_index;
            held_lines = it.column_lines;
        end else if (pick < row_w + read_w) begin
            it.command = CMD_READ;
        end else if (pick < row_w + read_w + rel_w) begin
            it.command = CMD_RELEASE;
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: stall pattern switches among a few shapes, including runs with
    // no stall at all. The long hold-off is ORed in from its own process.
    // ------------------------------------------------------------------------
    logic [1:0]  stall_mode = STALL_NONE;
    int unsigned stall_left = 0;
    logic        stall_bit;
    logic        hold_off   = 1'b0;

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_left <= $urandom_range(8, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:   stall_bit = 1'b0;
            STALL_SPARSE: stall_bit = ($urandom_range(0, 3) == 0);
            STALL_DENSE:  stall_bit = ($urandom_range(0, 3) != 0);
            default:      stall_bit = ~i_out_stall;
        endcase
        i_out_stall <= hold_off | stall_bit;
    end

    // Long hold-off mid-run: the sender keeps offering items, so the result
    // register and operation queue fill and the input side must stall.
    initial begin
        wait (items_accepted >= HOLD_OFF_AT);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result item against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result: stored=%0d valid=%0d key=%0d",
                    o_out_data.key_stored, o_out_data.read_valid, o_out_data.read_key));
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.key_stored !== want.key_stored ||
                    o_out_data.read_valid !== want.read_valid ||
                    o_out_data.read_key   !== want.read_key) begin
                    report_mismatch($sformatf(
                        "mismatch: expected stored=%0d valid=%0d key=%0d, got %0d %0d %0d",
                        want.key_stored, want.read_valid, want.read_key,
                        o_out_data.key_stored, o_out_data.read_valid,
                        o_out_data.read_key));
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[keypad_scan_key_buffer_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned mix;
        mix = MIX_BALANCED;
        for (int k = 0; k < RING_DEPTH; k++) begin
            ring_codes[k] = '0;
            ring_used[k]  = 1'b0;
        end
        wr_slot         = 0;
        rd_slot         = 0;
        last_code       = '0;
        last_code_known = 1'b0;

        //       command      row   lines   typed st rv key
        add_step(CMD_READ,    2'd0, 3'b111, 1'b1, 0, 0, 5'd0);   // empty after reset
        add_step(CMD_ROW,     2'd0, 3'b111, 1'b1, 0, 0, 5'd0);   // nothing pressed
        add_step(CMD_ROW,     2'd0, 3'b110, 1'b1, 1, 0, 5'd0);   // key 1
        add_step(CMD_ROW,     2'd0, 3'b110, 1'b1, 0, 0, 5'd0);   // held, no repeat
        add_step(CMD_RELEASE, 2'd0, 3'b111, 1'b1, 0, 0, 5'd0);
        add_step(CMD_ROW,     2'd0, 3'b110, 1'b1, 1, 0, 5'd0);   // key 1 again
        add_step(CMD_ROW,     2'd3, 3'b000, 1'b1, 1, 0, 5'd0);   // all pressed: star
        add_step(CMD_ROW,     2'd3, 3'b101, 1'b1, 1, 0, 5'd0);   // zero, ring now full
        add_step(CMD_ROW,     2'd3, 3'b011, 1'b1, 1, 0, 5'd0);   // hash overwrites
        add_step(CMD_ROW,     2'd2, 3'b011, 1'b1, 1, 0, 5'd0);   // 9 overwrites
        add_step(CMD_UNUSED,  2'd3, 3'b000, 1'b1, 0, 0, 5'd0);   // ignored command
        add_step(CMD_READ,    2'd1, 3'b010, 1'b1, 0, 1, CODE_HASH);
        add_step(CMD_READ,    2'd0, 3'b000, 1'b1, 0, 1, 5'd9);
        add_step(CMD_READ,    2'd2, 3'b101, 1'b1, 0, 1, CODE_STAR);
        add_step(CMD_READ,    2'd3, 3'b111, 1'b1, 0, 1, CODE_ZERO);
        add_step(CMD_READ,    2'd0, 3'b111, 1'b1, 0, 0, 5'd0);   // drained: empty read
        add_step(CMD_ROW,     2'd1, 3'b101, 1'b0, 0, 0, 5'd0);
        add_step(CMD_ROW,     2'd2, 3'b110, 1'b0, 0, 0, 5'd0);
        add_step(CMD_RELEASE, 2'd3, 3'b000, 1'b0, 0, 0, 5'd0);
        add_step(CMD_ROW,     2'd2, 3'b110, 1'b0, 0, 0, 5'd0);
        add_step(CMD_ROW,     2'd1, 3'b011, 1'b0, 0, 0, 5'd0);
        add_step(CMD_ROW,     2'd0, 3'b010, 1'b0, 0, 0, 5'd0);
        add_step(CMD_READ,    2'd2, 3'b100, 1'b0, 0, 0, 5'd0);
        add_step(CMD_READ,    2'd1, 3'b001, 1'b0, 0, 0, 5'd0);
        add_step(CMD_ROW,     2'd3, 3'b110, 1'b0, 0, 0, 5'd0);

        // synchronous reset held low, then released at a falling edge
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_steps[k]) begin
            send_item(directed_steps[k].stim, directed_steps[k].typed,
                      directed_steps[k].want);
        end

        // random part, traffic mix changes every 64 items so the ring both
        // overflows and runs dry
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                mix = $urandom_range(MIX_WRITES, MIX_BALANCED);
            end
            send_item(make_scan_item(mix), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        // watch for stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results missing at end of run");
        end

        if (mismatches == 0) begin
            $display("[keypad_scan_key_buffer_top] OK");
        end else begin
            $display("[keypad_scan_key_buffer_top] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/kpsb_pkg.sv
sv/kpsb_front.sv
sv/kpsb_queue.sv
sv/kpsb_back.sv
sv/keypad_scan_key_buffer_top.sv
tb/tb_top.sv
